// ----- sv/kpvt_pkg.sv -----
// Package for the position/velocity tracker: payload structs, controller commands,
// fixed-point constants and saturation helpers.
// No dependencies.
package kpvt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W = 48;
  localparam int CFG_W = 16;
  localparam int MS_W = 12;
  localparam int OUT_W = 32;
  localparam int DIG_W = 16;
  localparam int PC_W = 6;

  localparam logic signed [VAL_W-1:0] POS48 = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] NEG48 = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] MAG48 = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] RST_SCALE = 16'd1500;
  localparam logic [CFG_W-1:0] RST_RNOISE = 16'd30;
  localparam logic [CFG_W-1:0] RST_INITPOS = 16'd650;
  localparam logic [CFG_W-1:0] RST_INITVAR = 16'd1;

  // Milliseconds to seconds: divide by 1000 with halves rounding up.
  localparam logic [9:0] DT_DIVISOR = 10'd1000;
  localparam logic [8:0] DT_ROUND = 9'd500;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [1:0] {
    CFG_SCALE   = 2'd0,
    CFG_RNOISE  = 2'd1,
    CFG_INITPOS = 2'd2,
    CFG_INITVAR = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_ADD, OP_ADD3, OP_SUB, OP_MUL, OP_SCL0, OP_SCL1, OP_SCL2,
    OP_DIVDT, OP_DIVK, OP_BRANCH, OP_DONE
  } op_t;

  typedef enum logic [4:0] {
    SEL_ZERO, SEL_DT, SEL_DT2, SEL_DT3, SEL_DT4, SEL_QPP, SEL_QPV, SEL_QVV,
    SEL_TMP, SEL_TMP2, SEL_X0P, SEL_T, SEL_P00P, SEL_P01P, SEL_P11P, SEL_S,
    SEL_K0, SEL_K1, SEL_Y, SEL_POS, SEL_VEL, SEL_PP, SEL_PV, SEL_VV,
    SEL_RSH, SEL_DEPTH, SEL_SCALE
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t a;
    sel_t b;
    sel_t c;
    sel_t dst;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic in_load;
    logic out_load;
    logic cfg_we;
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic done;
    logic s_pos;
  } status_t;

  typedef struct packed {
    logic [MS_W-1:0]  delta_ms;
    logic [CFG_W-1:0] depth_mm;
  } in_t;

  typedef struct packed {
    logic [CFG_W-1:0]        observed_mm;
    logic signed [OUT_W-1:0] predicted_pos;
    logic signed [OUT_W-1:0] updated_pos;
  } out_t;

  // Saturate a wide sum to the 48-bit state range.
  function automatic val_t sat48(input logic signed [VAL_W+1:0] v);
    if (v[VAL_W+1:VAL_W-1] == {3{v[VAL_W+1]}}) return v[VAL_W-1:0];
    return v[VAL_W+1] ? NEG48 : POS48;
  endfunction

  // Saturate a state value to the 32-bit output range.
  function automatic logic signed [OUT_W-1:0] sat32(input val_t v);
    if (v[VAL_W-1:OUT_W-1] == {(VAL_W-OUT_W+1){v[VAL_W-1]}}) return v[OUT_W-1:0];
    return v[VAL_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  function automatic logic [VAL_W-1:0] mag48(input val_t v);
    return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
  endfunction

  // Apply a sign to a magnitude already capped at 2^47.
  function automatic val_t sgn_sat(input logic [VAL_W-1:0] m, input logic neg);
    if (neg) return VAL_W'(-m);
    return m[VAL_W-1] ? POS48 : val_t'(m);
  endfunction

endpackage

// ----- sv/kpvt_ctrl.sv -----
// Controller for the tracker: a sequencer that steps through the filter program
// and drives the datapath by command. Depends on kpvt_pkg.
module kpvt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  kpvt_pkg::status_t status,
  output kpvt_pkg::ctl_t    ctl
);
  import kpvt_pkg::*;

  localparam logic [PC_W-1:0] ELSE_PC = 6'd32;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic out_valid_next;
  cmd_t cmd;

  function automatic cmd_t mk(input op_t op, input sel_t a, input sel_t b,
                              input sel_t c, input sel_t dst);
    cmd_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    r.c = c;
    r.dst = dst;
    return r;
  endfunction

  // Filter program: prediction, innovation check, then correction or copy.
  function automatic cmd_t prog(input logic [PC_W-1:0] p);
    cmd_t r;
    unique case (p)
      6'd0:  r = mk(OP_DIVDT, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_DT);
      6'd1:  r = mk(OP_MUL, SEL_DT, SEL_DT, SEL_ZERO, SEL_DT2);
      6'd2:  r = mk(OP_MUL, SEL_DT2, SEL_DT, SEL_ZERO, SEL_DT3);
      6'd3:  r = mk(OP_MUL, SEL_DT3, SEL_DT, SEL_ZERO, SEL_DT4);
      6'd4:  r = mk(OP_SCL2, SEL_SCALE, SEL_DT4, SEL_ZERO, SEL_QPP);
      6'd5:  r = mk(OP_SCL1, SEL_SCALE, SEL_DT3, SEL_ZERO, SEL_QPV);
      6'd6:  r = mk(OP_SCL0, SEL_SCALE, SEL_DT2, SEL_ZERO, SEL_QVV);
      6'd7:  r = mk(OP_MUL, SEL_DT, SEL_VEL, SEL_ZERO, SEL_TMP);
      6'd8:  r = mk(OP_ADD, SEL_POS, SEL_TMP, SEL_ZERO, SEL_X0P);
      6'd9:  r = mk(OP_MUL, SEL_DT, SEL_VV, SEL_ZERO, SEL_TMP);
      6'd10: r = mk(OP_ADD, SEL_PV, SEL_TMP, SEL_ZERO, SEL_T);
      6'd11: r = mk(OP_MUL, SEL_DT, SEL_PV, SEL_ZERO, SEL_TMP);
      6'd12: r = mk(OP_MUL, SEL_DT, SEL_T, SEL_ZERO, SEL_TMP2);
      6'd13: r = mk(OP_ADD3, SEL_PP, SEL_TMP, SEL_TMP2, SEL_P00P);
      6'd14: r = mk(OP_ADD, SEL_P00P, SEL_QPP, SEL_ZERO, SEL_P00P);
      6'd15: r = mk(OP_ADD, SEL_T, SEL_QPV, SEL_ZERO, SEL_P01P);
      6'd16: r = mk(OP_ADD, SEL_VV, SEL_QVV, SEL_ZERO, SEL_P11P);
      6'd17: r = mk(OP_ADD, SEL_P00P, SEL_RSH, SEL_ZERO, SEL_S);
      6'd18: r = mk(OP_BRANCH, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO);
      6'd19: r = mk(OP_DIVK, SEL_P00P, SEL_P01P, SEL_S, SEL_K0);
      6'd20: r = mk(OP_SUB, SEL_DEPTH, SEL_X0P, SEL_ZERO, SEL_Y);
      6'd21: r = mk(OP_MUL, SEL_K0, SEL_Y, SEL_ZERO, SEL_TMP);
      6'd22: r = mk(OP_ADD, SEL_X0P, SEL_TMP, SEL_ZERO, SEL_POS);
      6'd23: r = mk(OP_MUL, SEL_K1, SEL_Y, SEL_ZERO, SEL_TMP);
      6'd24: r = mk(OP_ADD, SEL_VEL, SEL_TMP, SEL_ZERO, SEL_VEL);
      6'd25: r = mk(OP_MUL, SEL_K0, SEL_P00P, SEL_ZERO, SEL_TMP);
      6'd26: r = mk(OP_SUB, SEL_P00P, SEL_TMP, SEL_ZERO, SEL_PP);
      6'd27: r = mk(OP_MUL, SEL_K0, SEL_P01P, SEL_ZERO, SEL_TMP);
      6'd28: r = mk(OP_SUB, SEL_P01P, SEL_TMP, SEL_ZERO, SEL_PV);
      6'd29: r = mk(OP_MUL, SEL_K1, SEL_P01P, SEL_ZERO, SEL_TMP);
      6'd30: r = mk(OP_SUB, SEL_P11P, SEL_TMP, SEL_ZERO, SEL_VV);
      6'd32: r = mk(OP_ADD, SEL_X0P, SEL_ZERO, SEL_ZERO, SEL_POS);
      6'd33: r = mk(OP_ADD, SEL_P00P, SEL_ZERO, SEL_ZERO, SEL_PP);
      6'd34: r = mk(OP_ADD, SEL_P01P, SEL_ZERO, SEL_ZERO, SEL_PV);
      6'd35: r = mk(OP_ADD, SEL_P11P, SEL_ZERO, SEL_ZERO, SEL_VV);
      default: r = mk(OP_DONE, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO);
    endcase
    return r;
  endfunction

  assign cmd = prog(pc);
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Next state, program counter and command strobes.
  always_comb begin
    state_next = state;
    pc_next = pc;
    ctl.start = 1'b0;
    ctl.in_load = 1'b0;
    ctl.out_load = 1'b0;
    ctl.cfg_we = cfg_valid && cfg_ready;
    ctl.cmd = cmd;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.in_load = 1'b1;
          pc_next = '0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd.op) inside
          OP_ADD, OP_ADD3, OP_SUB: begin
            ctl.start = 1'b1;
            pc_next = pc + 1'b1;
          end
          OP_BRANCH: begin
            pc_next = status.s_pos ? pc + 1'b1 : ELSE_PC;
          end
          OP_DONE: begin
            state_next = S_OUT;
          end
          default: begin
            ctl.start = 1'b1;
            state_next = S_WAIT;
          end
        endcase
      end
      S_WAIT: begin
        if (status.done) begin
          pc_next = pc + 1'b1;
          state_next = S_EXEC;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          ctl.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output request flag: set on load, cleared when taken.
  always_comb begin
    out_valid_next = out_valid;
    if (ctl.out_load) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- sv/kpvt_dp.sv -----
// Datapath for the tracker: filter state, working registers, a saturating adder,
// a digit-serial multiplier, a reciprocal dt unit and a two-lane bit-serial divider.
// Depends on kpvt_pkg.
module kpvt_dp #(
  parameter int FRAC_BITS = kpvt_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kpvt_pkg::ctl_t             ctl,
  input  kpvt_pkg::in_t              in_data,
  input  kpvt_pkg::cfg_idx_t         cfg_index,
  input  logic [kpvt_pkg::CFG_W-1:0] cfg_data,
  output kpvt_pkg::status_t          status,
  output kpvt_pkg::out_t             out_data
);
  import kpvt_pkg::*;

  localparam int NUM_W = VAL_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int PROD_W = DIG_W + VAL_W;
  localparam int ACC_W = 2 * VAL_W;

  // dt = floor(num / 1000) as floor(num * M / 2^DT_K), exact for every num below 2^DT_NW.
  localparam int DT_NW = MS_W + FRAC_BITS + 1;
  localparam int DT_K = DT_NW + 10;
  localparam int DT_RW = DT_NW + 1;
  localparam int DT_PW = DT_NW + DT_RW;
  localparam logic [63:0] DT_RECIP_FULL =
    ((64'd1 << DT_K) + 64'(DT_DIVISOR) - 64'd1) / 64'(DT_DIVISOR);
  localparam logic [DT_RW-1:0] DT_RECIP = DT_RECIP_FULL[DT_RW-1:0];

  // Latched request, configuration and filter state.
  logic [DT_NW-1:0] dt_num;
  logic [CFG_W-1:0] depth_q, scale, rnoise;
  val_t pos, vel, pp, pv, vv;
  val_t dt, dt2, dt3, dt4, qpp, qpv, qvv, tmp, tmp2, x0p, tv, p00p, p01p, p11p;
  val_t s, k0, k1, y;
  val_t rsh, depth_sh, scale_v;

  assign rsh = val_t'(VAL_W'(rnoise) << FRAC_BITS);
  assign depth_sh = val_t'(VAL_W'(depth_q) << FRAC_BITS);
  assign scale_v = val_t'(VAL_W'(scale));

  function automatic val_t pick(input sel_t sel);
    val_t v;
    unique case (sel)
      SEL_ZERO:  v = '0;
      SEL_DT:    v = dt;
      SEL_DT2:   v = dt2;
      SEL_DT3:   v = dt3;
      SEL_DT4:   v = dt4;
      SEL_QPP:   v = qpp;
      SEL_QPV:   v = qpv;
      SEL_QVV:   v = qvv;
      SEL_TMP:   v = tmp;
      SEL_TMP2:  v = tmp2;
      SEL_X0P:   v = x0p;
      SEL_T:     v = tv;
      SEL_P00P:  v = p00p;
      SEL_P01P:  v = p01p;
      SEL_P11P:  v = p11p;
      SEL_S:     v = s;
      SEL_K0:    v = k0;
      SEL_K1:    v = k1;
      SEL_Y:     v = y;
      SEL_POS:   v = pos;
      SEL_VEL:   v = vel;
      SEL_PP:    v = pp;
      SEL_PV:    v = pv;
      SEL_VV:    v = vv;
      SEL_RSH:   v = rsh;
      SEL_DEPTH: v = depth_sh;
      SEL_SCALE: v = scale_v;
      default:   v = '0;
    endcase
    return v;
  endfunction

  val_t opa, opb, opc;
  assign opa = pick(ctl.cmd.a);
  assign opb = pick(ctl.cmd.b);
  assign opc = pick(ctl.cmd.c);

  // Saturating adder for sums and differences.
  logic signed [VAL_W+1:0] add_sum;
  always_comb begin
    case (ctl.cmd.op)
      OP_SUB:  add_sum = (VAL_W+2)'(opa) - (VAL_W+2)'(opb);
      OP_ADD3: add_sum = (VAL_W+2)'(opa) + (VAL_W+2)'(opb) + (VAL_W+2)'(opc);
      default: add_sum = (VAL_W+2)'(opa) + (VAL_W+2)'(opb);
    endcase
  end

  // Digit-serial multiplier: one 16-bit digit of the first operand per cycle.
  logic mul_busy, mul_neg, mul_done, mul_start;
  logic [2:0] mul_cnt;
  logic [VAL_W-1:0] mul_ma, mul_mb;
  logic [DIG_W-1:0] mul_dig;
  logic [PROD_W-1:0] mul_prod;
  logic [ACC_W-1:0] mul_acc;

  assign mul_start = ctl.start && (ctl.cmd.op == OP_MUL || ctl.cmd.op == OP_SCL0 ||
                     ctl.cmd.op == OP_SCL1 || ctl.cmd.op == OP_SCL2);
  assign mul_done = mul_busy && (mul_cnt == 3'd4);

  always_comb begin
    case (mul_cnt)
      3'd0:    mul_dig = mul_ma[47:32];
      3'd1:    mul_dig = mul_ma[31:16];
      3'd2:    mul_dig = mul_ma[15:0];
      default: mul_dig = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
    end else if (mul_start) begin
      mul_busy <= 1'b1;
    end else if (mul_done) begin
      mul_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_ma <= mag48(opa);
      mul_mb <= mag48(opb);
      mul_neg <= opa[VAL_W-1] ^ opb[VAL_W-1];
      mul_cnt <= '0;
      mul_acc <= '0;
    end else if (mul_busy) begin
      mul_cnt <= mul_cnt + 1'b1;
      mul_prod <= PROD_W'(mul_dig) * PROD_W'(mul_mb);
      if (mul_cnt != 3'd0) mul_acc <= (mul_acc << DIG_W) + ACC_W'(mul_prod);
    end
  end

  // Fixed-point product: round half away from zero, then saturate.
  logic [ACC_W:0] mul_rnd, mul_sh, scl_sum, scl_sh;
  logic [VAL_W-1:0] mul_mag;
  val_t mul_res, scl_res;
  logic [1:0] scl_shift;

  assign mul_rnd = (ACC_W+1)'(mul_acc) + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
  assign mul_sh = mul_rnd >> FRAC_BITS;
  assign mul_mag = (|mul_sh[ACC_W:VAL_W-1]) ? MAG48 : {1'b0, mul_sh[VAL_W-2:0]};
  assign mul_res = sgn_sat(mul_mag, mul_neg);

  // Process noise terms: scale times a power of dt, shifted with rounding and capped.
  always_comb begin
    case (ctl.cmd.op)
      OP_SCL2: scl_shift = 2'd2;
      OP_SCL1: scl_shift = 2'd1;
      default: scl_shift = 2'd0;
    endcase
  end
  assign scl_sum = (ACC_W+1)'(mul_acc) + (((ACC_W+1)'(1) << scl_shift) >> 1);
  assign scl_sh = scl_sum >> scl_shift;
  assign scl_res = (|scl_sh[ACC_W:VAL_W-1]) ? POS48 : val_t'({1'b0, scl_sh[VAL_W-2:0]});

  // Time step: the rounded numerator is latched with the request, then one
  // registered multiply by the reciprocal of 1000 gives dt on the next cycle.
  logic dt_busy, dt_done, dt_start;
  logic [DT_PW-1:0] dt_prod;
  val_t dt_res;

  assign dt_start = ctl.start && (ctl.cmd.op == OP_DIVDT);
  assign dt_done = dt_busy;
  assign dt_res = val_t'(VAL_W'(dt_prod >> DT_K));

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_busy <= 1'b0;
    end else begin
      dt_busy <= dt_start;
    end
  end

  always_ff @(posedge clk) begin
    if (dt_start) begin
      dt_prod <= DT_PW'(dt_num) * DT_PW'(DT_RECIP);
    end
  end

  // Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
  logic div_busy, div_done, div_start, div_neg0, div_neg1;
  logic [DCNT_W-1:0] div_cnt;
  logic [NUM_W-1:0] div_n0, div_n1;
  logic [VAL_W:0] div_r0, div_r1, div_sh0, div_sh1;
  logic [VAL_W-1:0] div_d, div_m0, div_m1;
  logic div_ge0, div_ge1;
  val_t div_q0, div_q1;

  assign div_start = ctl.start && (ctl.cmd.op == OP_DIVK);
  assign div_done = div_busy && (div_cnt == DCNT_W'(NUM_W));
  assign div_sh0 = {div_r0[VAL_W-1:0], div_n0[NUM_W-1]};
  assign div_sh1 = {div_r1[VAL_W-1:0], div_n1[NUM_W-1]};
  assign div_ge0 = div_sh0 >= {1'b0, div_d};
  assign div_ge1 = div_sh1 >= {1'b0, div_d};
  assign div_m0 = (|div_n0[NUM_W-1:VAL_W-1]) ? MAG48 : {1'b0, div_n0[VAL_W-2:0]};
  assign div_m1 = (|div_n1[NUM_W-1:VAL_W-1]) ? MAG48 : {1'b0, div_n1[VAL_W-2:0]};
  assign div_q0 = sgn_sat(div_m0, div_neg0);
  assign div_q1 = sgn_sat(div_m1, div_neg1);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (div_start) begin
      div_busy <= 1'b1;
    end else if (div_done) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_cnt <= '0;
      div_r0 <= '0;
      div_r1 <= '0;
      div_n0 <= NUM_W'(mag48(opa)) << FRAC_BITS;
      div_n1 <= NUM_W'(mag48(opb)) << FRAC_BITS;
      div_d <= VAL_W'(opc);
      div_neg0 <= opa[VAL_W-1];
      div_neg1 <= opb[VAL_W-1];
    end else if (div_busy && !div_done) begin
      div_cnt <= div_cnt + 1'b1;
      div_r0 <= div_ge0 ? div_sh0 - {1'b0, div_d} : div_sh0;
      div_r1 <= div_ge1 ? div_sh1 - {1'b0, div_d} : div_sh1;
      div_n0 <= {div_n0[NUM_W-2:0], div_ge0};
      div_n1 <= {div_n1[NUM_W-2:0], div_ge1};
    end
  end

  // Result write selection.
  logic wr_en, wr_k;
  val_t wr_val;
  always_comb begin
    wr_en = 1'b0;
    wr_k = 1'b0;
    wr_val = sat48(add_sum);
    if (ctl.start && (ctl.cmd.op == OP_ADD || ctl.cmd.op == OP_ADD3 ||
                      ctl.cmd.op == OP_SUB)) begin
      wr_en = 1'b1;
    end else if (mul_done) begin
      wr_en = 1'b1;
      wr_val = (ctl.cmd.op == OP_MUL) ? mul_res : scl_res;
    end else if (dt_done) begin
      wr_en = 1'b1;
      wr_val = dt_res;
    end else if (div_done) begin
      wr_k = 1'b1;
    end
  end

  assign status.done = mul_done || dt_done || div_done;
  assign status.s_pos = !s[VAL_W-1] && (s != '0);

  // Working registers.
  always_ff @(posedge clk) begin
    if (ctl.in_load) begin
      dt_num <= (DT_NW'(in_data.delta_ms) << FRAC_BITS) + DT_NW'(DT_ROUND);
      depth_q <= in_data.depth_mm;
    end
    if (wr_k) begin
      k0 <= div_q0;
      k1 <= div_q1;
    end
    if (wr_en) begin
      case (ctl.cmd.dst)
        SEL_DT:   dt <= wr_val;
        SEL_DT2:  dt2 <= wr_val;
        SEL_DT3:  dt3 <= wr_val;
        SEL_DT4:  dt4 <= wr_val;
        SEL_QPP:  qpp <= wr_val;
        SEL_QPV:  qpv <= wr_val;
        SEL_QVV:  qvv <= wr_val;
        SEL_TMP:  tmp <= wr_val;
        SEL_TMP2: tmp2 <= wr_val;
        SEL_X0P:  x0p <= wr_val;
        SEL_T:    tv <= wr_val;
        SEL_P00P: p00p <= wr_val;
        SEL_P01P: p01p <= wr_val;
        SEL_P11P: p11p <= wr_val;
        SEL_S:    s <= wr_val;
        SEL_Y:    y <= wr_val;
        default: ;
      endcase
    end
  end

  // Filter state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= RST_SCALE;
      rnoise <= RST_RNOISE;
      pos <= val_t'(VAL_W'(RST_INITPOS) << FRAC_BITS);
      vel <= '0;
      pp <= val_t'(VAL_W'(RST_INITVAR) << FRAC_BITS);
      pv <= '0;
      vv <= val_t'(VAL_W'(RST_INITVAR) << FRAC_BITS);
    end else if (ctl.cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE:   scale <= cfg_data;
        CFG_RNOISE:  rnoise <= cfg_data;
        CFG_INITPOS: pos <= val_t'(VAL_W'(cfg_data) << FRAC_BITS);
        CFG_INITVAR: begin
          pp <= val_t'(VAL_W'(cfg_data) << FRAC_BITS);
          vv <= val_t'(VAL_W'(cfg_data) << FRAC_BITS);
        end
        default: ;
      endcase
    end else if (wr_en) begin
      case (ctl.cmd.dst)
        SEL_POS: pos <= wr_val;
        SEL_VEL: vel <= wr_val;
        SEL_PP:  pp <= wr_val;
        SEL_PV:  pv <= wr_val;
        SEL_VV:  vv <= wr_val;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data.observed_mm <= depth_q;
      out_data.predicted_pos <= sat32(x0p);
      out_data.updated_pos <= sat32(pos);
    end
  end

endmodule

// ----- sv/kalman_position_velocity_tracker_top.sv -----
// Top level of the two-state position/velocity Kalman tracker.
// Depends on kpvt_pkg, kpvt_ctrl and kpvt_dp.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    in_data  (delta_ms, depth_mm)
//   out      out_valid / out_stall  out_data (observed_mm, predicted_pos, updated_pos)
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A result is presented once the filter program has run; when S <= 0 the correction is
// skipped. The gain divider pass, fifteen multiplies on the shared digit-serial multiplier,
// the dt step and the adds make up the program. The next request can be accepted
// in the cycle after the result is loaded. Requests are processed one at a time.
// Reset (synchronous, active high) loads the default configuration and the start state.
// The output register lets a finished result wait under out_stall while the next
// request is accepted and processed; in_stall is high whenever the sequencer is busy.
module kalman_position_velocity_tracker_top #(
  parameter int FRAC_BITS = kpvt_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  kpvt_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output kpvt_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  kpvt_pkg::cfg_idx_t         cfg_index,
  input  logic [kpvt_pkg::CFG_W-1:0] cfg_data
);
  import kpvt_pkg::*;

  ctl_t ctl;
  status_t status;

  kpvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .ctl       (ctl)
  );

  kpvt_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_data  (out_data)
  );

  // An accepted request keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting a request");

  // Configuration is taken only while no request is in progress.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == !in_stall)
    else $error("configuration ready while busy");

  // A unit completion only happens during processing.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    status.done |-> in_stall)
    else $error("unit completion while idle");

  // Loading the output register always presents a result next cycle.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> out_valid)
    else $error("result not presented after load");

endmodule
